>>> src/phdh_pkg.sv
// ============================================================================
// phdh_pkg: shared types and constants of the pixel hit histogram core
// Field widths, timestamp-to-second constants, and the front-to-back and
// result records that travel between the decode front and the count back.
// ============================================================================
`default_nettype none

package phdh_pkg;

  // Header codes that mark a hit packet
  localparam logic [3:0] HDR_HIT_A = 4'hA;
  localparam logic [3:0] HDR_HIT_B = 4'hB;

  // Field widths
  localparam int TOT_VAL_W = 10;
  localparam int HIT_X_W   = 34;   // timestamp without its eight zero low bits
  localparam int HIT_T_W   = 42;
  localparam int SEC_W     = 5;    // seconds reachable by a 42-bit timestamp
  localparam int SEC_OUT_W = 7;
  localparam int RES_CNT_W = 32;

  // Hit map geometry
  localparam int MAP_SIDE  = 256;
  localparam int MAP_AW    = 16;
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;

  // Rounded seconds: sec = floor(((x << 8) + S/2) / S), S = 2^21 * 78125.
  // This equals floor(((x + 320000000) >> 13) / 78125).
  localparam int               TICKS_W     = 22;
  localparam int               TICK_SHIFT  = 13;
  localparam logic [34:0]      HALF_SEC_X  = 35'd320000000;
  localparam logic [21:0]      SEC_DIV     = 22'd78125;
  localparam int               RECIP_W     = 16;
  localparam logic [15:0]      RECIP       = 16'd54975;  // floor(2^32 / 78125)
  localparam int               RECIP_SHIFT = 32;
  localparam int               PROD_W      = TICKS_W + RECIP_W;

  // ToT counter selection
  typedef enum logic [1:0] {
    TOT_CLS_BIN   = 2'd0,
    TOT_CLS_UNDER = 2'd1,
    TOT_CLS_OVER  = 2'd2
  } tot_cls_t;

  // Classified hit, front to back
  typedef struct packed {
    logic                 hit;
    logic [7:0]           column;
    logic [7:0]           pixel_row;
    logic [TOT_VAL_W-1:0] tot_value;
    logic [HIT_X_W-1:0]   hit_x;
    tot_cls_t             tot_cls;
    logic [TOT_VAL_W-1:0] tot_idx;
    logic [SEC_W-1:0]     sec;
    logic                 rate_ok;
  } item_t;

  // Result beat
  typedef struct packed {
    logic                 is_hit;
    logic [7:0]           column;
    logic [7:0]           pixel_row;
    logic [TOT_VAL_W-1:0] tot_value;
    logic [HIT_T_W-1:0]   hit_time;
    logic [RES_CNT_W-1:0] tot_bin_count;
    logic [RES_CNT_W-1:0] map_count;
    logic [SEC_OUT_W-1:0] second_bin;
    logic [RES_CNT_W-1:0] rate_count;
  } res_t;

endpackage

`default_nettype wire

>>> src/phdh_fifo.sv
// ============================================================================
// phdh_fifo: small flop-based queue
// Push/full on the write side, pop/empty on the read side; the head entry is
// shown on rdata while empty is low.
// ============================================================================
`default_nettype none

module phdh_fifo #(
  parameter type entry_t = logic,
  parameter int  DEPTH   = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wdata,
  output logic        full,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push_fire, pop_fire;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign push_fire = push && !full;
  assign pop_fire  = pop && !empty;
  assign rdata     = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_fire, pop_fire})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> src/phdh_front.sv
// ============================================================================
// phdh_front: packet decode and classification
// Two stages: decode the packet and form the rounded tick count, then
// estimate the second by reciprocal multiply; the correction step feeds
// the queue toward the counting back end.
// ============================================================================
`default_nettype none

module phdh_front
  import phdh_pkg::*;
#(
  parameter int TOT_BINS  = 500,
  parameter int RATE_BINS = 100
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        hold,
  input  wire logic        in_push,
  input  wire logic [63:0] in_packet,
  output logic             in_full,
  output logic             q_push,
  output item_t            q_item,
  input  wire logic        q_full
);

  typedef struct packed {
    logic                 hit;
    logic [7:0]           column;
    logic [7:0]           pixel_row;
    logic [TOT_VAL_W-1:0] tot_value;
    logic [HIT_X_W-1:0]   hit_x;
    tot_cls_t             tot_cls;
    logic [TOT_VAL_W-1:0] tot_idx;
    logic [TICKS_W-1:0]   ticks;
  } dec_t;

  logic                  s1_v_r, s2_v_r;
  dec_t                  s1_r, s1_nxt, s2_r;
  logic [SEC_W-1:0]      s2_q_r, q_nxt;
  logic                  s1_rdy, s2_rdy, accept;

  logic [3:0]            head;
  logic [15:0]           addr;
  logic [TOT_VAL_W-1:0]  tot;
  logic [HIT_X_W:0]      rounded;
  logic [PROD_W-1:0]     prod;
  logic [TICKS_W-1:0]    rem;
  logic [SEC_W-1:0]      sec_fix;

  // Stall chain toward the queue
  assign s2_rdy  = !s2_v_r || !q_full;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_full = !s1_rdy || hold;
  assign accept  = in_push && !in_full;

  // Decode one packet
  always_comb begin
    head    = in_packet[63:60];
    addr    = in_packet[59:44];
    tot     = in_packet[29:20];
    s1_nxt  = '0;
    s1_nxt.hit       = (head inside {HDR_HIT_A, HDR_HIT_B});
    s1_nxt.column    = {addr[15:9], addr[2]};
    s1_nxt.pixel_row = {addr[8:3], addr[1:0]};
    s1_nxt.tot_value = tot;
    // link, coarse and inverted fine occupy disjoint bit ranges
    s1_nxt.hit_x     = {in_packet[15:0], in_packet[43:30], ~in_packet[19:16]};
    rounded          = {1'b0, s1_nxt.hit_x} + HALF_SEC_X;
    s1_nxt.ticks     = rounded[TICK_SHIFT +: TICKS_W];
    s1_nxt.tot_idx   = tot - 1'b1;
    if (tot == '0) begin
      s1_nxt.tot_cls = TOT_CLS_UNDER;
    end else if (int'(tot) > TOT_BINS) begin
      s1_nxt.tot_cls = TOT_CLS_OVER;
    end else begin
      s1_nxt.tot_cls = TOT_CLS_BIN;
    end
  end

  // Estimate seconds, low by at most one
  assign prod  = PROD_W'(s1_r.ticks) * PROD_W'(RECIP);
  assign q_nxt = prod[RECIP_SHIFT +: SEC_W];

  // Correct the estimate and build the queue entry
  always_comb begin
    rem     = s2_r.ticks - (TICKS_W'(s2_q_r) * SEC_DIV);
    sec_fix = (rem >= SEC_DIV) ? s2_q_r + 1'b1 : s2_q_r;
    q_item.hit       = s2_r.hit;
    q_item.column    = s2_r.column;
    q_item.pixel_row = s2_r.pixel_row;
    q_item.tot_value = s2_r.tot_value;
    q_item.hit_x     = s2_r.hit_x;
    q_item.tot_cls   = s2_r.tot_cls;
    q_item.tot_idx   = s2_r.tot_idx;
    q_item.sec       = sec_fix;
    q_item.rate_ok   = (int'(sec_fix) < RATE_BINS);
  end

  assign q_push = s2_v_r;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= accept;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (s1_rdy && accept) begin
      s1_r <= s1_nxt;
    end
    if (s2_rdy && s1_v_r) begin
      s2_r   <= s1_r;
      s2_q_r <= q_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/phdh_back.sv
// ============================================================================
// phdh_back: histogram read-modify-write
// Reads the ToT, hit map and rate memories for the queue head, then adds one
// with saturation, writes back and emits the result beat. The last write of
// each memory is forwarded to the following item. Clears all memories after
// reset, one address per cycle.
// ============================================================================
`default_nettype none

module phdh_back
  import phdh_pkg::*;
#(
  parameter int TOT_BINS    = 500,
  parameter int RATE_BINS   = 100,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t q_item,
  input  wire logic  q_empty,
  output logic       q_pop,
  output res_t       res_item,
  output logic       res_push,
  input  wire logic  res_full,
  output logic       clr_busy
);

  localparam int TOT_AW  = (TOT_BINS > 1) ? $clog2(TOT_BINS) : 1;
  localparam int RATE_AW = $clog2(RATE_BINS);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  localparam cnt_t CNT_MAX = '1;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // Memories and read registers
  cnt_t tot_mem  [TOT_BINS];
  cnt_t map_mem  [MAP_DEPTH];
  cnt_t rate_mem [RATE_BINS];
  cnt_t tot_rd_r, map_rd_r, rate_rd_r;

  // Clearing pass
  logic              clr_busy_r;
  logic [MAP_AW-1:0] clr_addr_r;

  // Count stage
  logic  b_v_r, b_rdy, b_fire, rd_en, item_wr;
  item_t b_item_r;

  // Last write of each store
  logic              tot_lw_v_r, map_lw_v_r, rate_lw_v_r;
  logic [TOT_AW-1:0] tot_lw_a_r;
  logic [MAP_AW-1:0] map_lw_a_r;
  logic [RATE_AW-1:0] rate_lw_a_r;
  cnt_t              tot_lw_d_r, map_lw_d_r, rate_lw_d_r;

  cnt_t under_r, over_r;

  logic [TOT_AW-1:0]  tot_ra, b_tot_a, tot_wa;
  logic [MAP_AW-1:0]  map_ra, b_map_a, map_wa;
  logic [RATE_AW-1:0] rate_ra, b_rate_a, rate_wa;
  cnt_t tot_fwd, map_fwd, rate_fwd;
  cnt_t tot_cur, tot_new, map_new, rate_new;
  cnt_t tot_wd, map_wd, rate_wd;
  logic tot_we, map_we, rate_we;
  logic tot_we_item, rate_we_item;

  assign clr_busy = clr_busy_r;

  // Handshake between queue head, count stage and result queue
  assign b_rdy    = !b_v_r || !res_full;
  assign b_fire   = b_v_r && !res_full;
  assign rd_en    = !q_empty && b_rdy && !clr_busy_r;
  assign q_pop    = rd_en;
  assign res_push = b_fire;

  // Read addresses of the queue head
  assign tot_ra  = q_item.tot_idx[TOT_AW-1:0];
  assign map_ra  = {q_item.column, q_item.pixel_row};
  assign rate_ra = RATE_AW'(q_item.sec);

  assign b_tot_a  = b_item_r.tot_idx[TOT_AW-1:0];
  assign b_map_a  = {b_item_r.column, b_item_r.pixel_row};
  assign b_rate_a = RATE_AW'(b_item_r.sec);

  // Forward the write that landed with this item's read
  assign tot_fwd  = (tot_lw_v_r && tot_lw_a_r == b_tot_a) ? tot_lw_d_r : tot_rd_r;
  assign map_fwd  = (map_lw_v_r && map_lw_a_r == b_map_a) ? map_lw_d_r : map_rd_r;
  assign rate_fwd = (rate_lw_v_r && rate_lw_a_r == b_rate_a) ? rate_lw_d_r : rate_rd_r;

  // Pick the ToT counter and bump all three
  always_comb begin
    case (b_item_r.tot_cls)
      TOT_CLS_UNDER: tot_cur = under_r;
      TOT_CLS_OVER:  tot_cur = over_r;
      TOT_CLS_BIN:   tot_cur = tot_fwd;
      default:       tot_cur = tot_fwd;
    endcase
    tot_new  = sat_inc(tot_cur);
    map_new  = sat_inc(map_fwd);
    rate_new = sat_inc(rate_fwd);
  end

  assign item_wr      = b_fire && b_item_r.hit;
  assign tot_we_item  = item_wr && (b_item_r.tot_cls == TOT_CLS_BIN);
  assign rate_we_item = item_wr && b_item_r.rate_ok;

  // Write ports: clearing pass or item update
  always_comb begin
    if (clr_busy_r) begin
      tot_we  = (int'(clr_addr_r) < TOT_BINS);
      tot_wa  = clr_addr_r[TOT_AW-1:0];
      tot_wd  = '0;
      map_we  = 1'b1;
      map_wa  = clr_addr_r;
      map_wd  = '0;
      rate_we = (int'(clr_addr_r) < RATE_BINS);
      rate_wa = clr_addr_r[RATE_AW-1:0];
      rate_wd = '0;
    end else begin
      tot_we  = tot_we_item;
      tot_wa  = b_tot_a;
      tot_wd  = tot_new;
      map_we  = item_wr;
      map_wa  = b_map_a;
      map_wd  = map_new;
      rate_we = rate_we_item;
      rate_wa = b_rate_a;
      rate_wd = rate_new;
    end
  end

  // ToT memory
  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_wa] <= tot_wd;
    end
    if (rd_en) begin
      tot_rd_r <= tot_mem[tot_ra];
    end
  end

  // Hit map memory
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (rd_en) begin
      map_rd_r <= map_mem[map_ra];
    end
  end

  // Rate memory
  always_ff @(posedge clk) begin
    if (rate_we) begin
      rate_mem[rate_wa] <= rate_wd;
    end
    if (rd_en) begin
      rate_rd_r <= rate_mem[rate_ra];
    end
  end

  // Control: clearing pass, stage valid, last-write marks, edge counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      b_v_r       <= 1'b0;
      tot_lw_v_r  <= 1'b0;
      map_lw_v_r  <= 1'b0;
      rate_lw_v_r <= 1'b0;
      under_r     <= '0;
      over_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (b_rdy) begin
        b_v_r <= rd_en;
      end
      if (tot_we_item) begin
        tot_lw_v_r <= 1'b1;
      end
      if (item_wr) begin
        map_lw_v_r <= 1'b1;
      end
      if (rate_we_item) begin
        rate_lw_v_r <= 1'b1;
      end
      if (item_wr && b_item_r.tot_cls == TOT_CLS_UNDER) begin
        under_r <= tot_new;
      end
      if (item_wr && b_item_r.tot_cls == TOT_CLS_OVER) begin
        over_r <= tot_new;
      end
    end
  end

  // Payload: stage item and last-write data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      b_item_r <= q_item;
    end
    if (tot_we_item) begin
      tot_lw_a_r <= b_tot_a;
      tot_lw_d_r <= tot_new;
    end
    if (item_wr) begin
      map_lw_a_r <= b_map_a;
      map_lw_d_r <= map_new;
    end
    if (rate_we_item) begin
      rate_lw_a_r <= b_rate_a;
      rate_lw_d_r <= rate_new;
    end
  end

  // Build the result beat; a non-hit gives all zero
  always_comb begin
    res_item = '0;
    if (b_item_r.hit) begin
      res_item.is_hit        = 1'b1;
      res_item.column        = b_item_r.column;
      res_item.pixel_row     = b_item_r.pixel_row;
      res_item.tot_value     = b_item_r.tot_value;
      res_item.hit_time      = {b_item_r.hit_x, 8'd0};
      res_item.tot_bin_count = RES_CNT_W'(tot_new);
      res_item.map_count     = RES_CNT_W'(map_new);
      res_item.second_bin    = SEC_OUT_W'(b_item_r.sec);
      res_item.rate_count    = b_item_r.rate_ok ? RES_CNT_W'(rate_new) : '0;
    end
  end

endmodule

`default_nettype wire

>>> src/pixel_hit_decode_histogram_core.sv
// ============================================================================
// pixel_hit_decode_histogram_core: pixel hit decoder with three histograms
// Decodes 64-bit readout packets into column, row, ToT and timestamp, and
// counts hits in saturating ToT, hit map and one-second rate histograms.
// ============================================================================
//
//   channel   handshake          payload
//   --------  -----------------  ----------------------------------------------
//   input     in_push / in_full  in_packet
//   result    out_pop/out_empty  out_is_hit, out_column, out_pixel_row,
//                                out_tot_value, out_hit_time, out_tot_bin_count,
//                                out_map_count, out_second_bin, out_rate_count
//
// One packet per cycle sustained while the result queue is drained and no clearing
// pass runs; a result passes two decode stages, the middle queue, the memory read
// with count stage and the result queue before it shows on the out_ ports.
// The rate is set by the one read and one write per cycle on each histogram
// memory, with the last write forwarded to the next packet.
// After reset a clearing pass over 65536 addresses zeroes all memories; in_full
// stays high meanwhile. A full result queue stalls the back end only; the
// front keeps decoding until the four-entry middle queue fills.
`default_nettype none

module pixel_hit_decode_histogram_core
  import phdh_pkg::*;
#(
  parameter int TOT_BINS    = 500,
  parameter int RATE_BINS   = 100,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [63:0]           in_packet,
  output logic                       in_full,
  input  wire logic                  out_pop,
  output logic                       out_empty,
  output logic                       out_is_hit,
  output logic [7:0]                 out_column,
  output logic [7:0]                 out_pixel_row,
  output logic [TOT_VAL_W-1:0]       out_tot_value,
  output logic [HIT_T_W-1:0]         out_hit_time,
  output logic [RES_CNT_W-1:0]       out_tot_bin_count,
  output logic [RES_CNT_W-1:0]       out_map_count,
  output logic [SEC_OUT_W-1:0]       out_second_bin,
  output logic [RES_CNT_W-1:0]       out_rate_count
);

  localparam int MID_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  logic  clr_busy;
  logic  mq_push, mq_full, mq_pop, mq_empty;
  item_t mq_wdata, mq_rdata;
  logic  rq_push, rq_full;
  res_t  rq_wdata, rq_rdata;

  // Decode and classify
  phdh_front #(
    .TOT_BINS  (TOT_BINS),
    .RATE_BINS (RATE_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clr_busy),
    .in_push   (in_push),
    .in_packet (in_packet),
    .in_full   (in_full),
    .q_push    (mq_push),
    .q_item    (mq_wdata),
    .q_full    (mq_full)
  );

  // Decouple front from back
  phdh_fifo #(
    .entry_t (item_t),
    .DEPTH   (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  // Count in the histograms
  phdh_back #(
    .TOT_BINS    (TOT_BINS),
    .RATE_BINS   (RATE_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_item   (mq_rdata),
    .q_empty  (mq_empty),
    .q_pop    (mq_pop),
    .res_item (rq_wdata),
    .res_push (rq_push),
    .res_full (rq_full),
    .clr_busy (clr_busy)
  );

  // Hold finished results for the consumer
  phdh_fifo #(
    .entry_t (res_t),
    .DEPTH   (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_is_hit        = rq_rdata.is_hit;
  assign out_column        = rq_rdata.column;
  assign out_pixel_row     = rq_rdata.pixel_row;
  assign out_tot_value     = rq_rdata.tot_value;
  assign out_hit_time      = rq_rdata.hit_time;
  assign out_tot_bin_count = rq_rdata.tot_bin_count;
  assign out_map_count     = rq_rdata.map_count;
  assign out_second_bin    = rq_rdata.second_bin;
  assign out_rate_count    = rq_rdata.rate_count;

endmodule

`default_nettype wire

>>> src/phdh_checker.sv
// ============================================================================
// phdh_checker: port-level checks of the pixel hit histogram core
// Watches the result queue and the start-up clearing pass.
// ============================================================================
`default_nettype none

module phdh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_full,
  input wire logic        out_pop,
  input wire logic        out_empty,
  input wire logic        out_is_hit,
  input wire logic [7:0]  out_column,
  input wire logic [7:0]  out_pixel_row,
  input wire logic [9:0]  out_tot_value,
  input wire logic [41:0] out_hit_time,
  input wire logic [31:0] out_tot_bin_count,
  input wire logic [31:0] out_map_count,
  input wire logic [6:0]  out_second_bin,
  input wire logic [31:0] out_rate_count
);

  // A non-hit beat carries nothing but zeros
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_is_hit) |->
      (out_column == 8'd0 && out_pixel_row == 8'd0 && out_tot_value == 10'd0 &&
       out_hit_time == 42'd0 && out_tot_bin_count == 32'd0 &&
       out_map_count == 32'd0 && out_second_bin == 7'd0 && out_rate_count == 32'd0))
    else $error("non-hit result with nonzero fields");

  // A hit timestamp has zero low byte and stays within 28 seconds
  a_hit_time: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_is_hit) |->
      (out_hit_time[7:0] == 8'd0 && out_second_bin < 7'd28))
    else $error("hit timestamp or rate bin out of range");

  // Right after reset the clearing pass blocks input and no result waits
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (in_full && out_empty))
    else $error("input open or result pending right after reset");

  // A result beat not taken holds
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_is_hit) && $stable(out_column) &&
       $stable(out_pixel_row) && $stable(out_tot_value) && $stable(out_hit_time) &&
       $stable(out_tot_bin_count) && $stable(out_map_count) &&
       $stable(out_second_bin) && $stable(out_rate_count)))
    else $error("stalled result beat changed");

endmodule

bind pixel_hit_decode_histogram_core phdh_checker u_phdh_checker (.*);

`default_nettype wire
